// ===== src/ready_queue_scheduler_core_assert.svh =====
// Assertion macros for the ready queue scheduler
`ifndef READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define READY_QUEUE_SCHEDULER_CORE_ASSERT_SVH

// checked outside reset
`define RQS_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RQS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/rqs_pkg.sv =====
// Shared types and codes of the ready queue scheduler
`timescale 1ns / 1ps
`default_nettype none
package rqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = 5;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // request kinds
    localparam logic [1:0] K_ADD    = 2'd0;
    localparam logic [1:0] K_REMOVE = 2'd1;
    localparam logic [1:0] K_TAKE   = 2'd2;

    // ordering policies
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // register index
    localparam logic REG_POLICY = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  process_id;
        logic [15:0] lifetime;
        logic [7:0]  priority_req;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  next_id;
        logic [4:0]  occupancy;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] lifetime;
        logic [7:0]  prio;
    } t_entry;

    // update strobes from the controller to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== src/rqs_cell.sv =====
// One queue slot: compares against the request and shifts with its neighbors
`timescale 1ns / 1ps
`default_nettype none
module rqs_cell
    import rqs_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  wire logic             i_clk,
    input  wire t_req             i_req,
    input  wire logic [1:0]       i_policy,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire t_cell_ctl        i_ctl,
    input  wire t_entry           i_prev,
    input  wire t_entry           i_next,
    input  wire logic             i_prev_ge,
    input  wire logic             i_prev_hit,
    output t_entry                o_entry,
    output logic                  o_ge,
    output logic                  o_hit
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_valid;
    logic   w_before;
    logic   w_match;
    t_entry w_new;

    assign w_valid = (CNT_W'(IDX) < i_count);
    assign w_match = w_valid && (r_entry.id == i_req.process_id);
    assign w_new   = '{id: i_req.process_id, lifetime: i_req.lifetime,
                       prio: i_req.priority_req};

    always_comb begin
        case (i_policy)
            POL_SJF:  w_before = (i_req.lifetime < r_entry.lifetime);
            POL_PRIO: w_before = (i_req.priority_req > r_entry.prio);
            default:  w_before = 1'b0;
        endcase
    end

    // queue is kept sorted, so ge is a step: false up to the slot, true from it on
    assign o_ge  = !w_valid || w_before;
    assign o_hit = i_prev_hit || w_match;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_prev_ge) begin
                n_entry = i_prev;
            end else if (o_ge) begin
                n_entry = w_new;
            end
        end else if (i_ctl.del && o_hit) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== src/ready_queue_scheduler_core.sv =====
// Ready queue scheduler top level: request control, register port, row of cells
//
//  channel   direction  handshake                  payload
//  request   in         i_req_valid / o_req_ready  i_req (t_req)
//  response  out        o_rsp_valid / i_rsp_ready  o_rsp (t_rsp)
//  config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// Each request is first captured in a register; then, as it executes, all cells
// compare in parallel and shift their entries by one slot.
// The remove/duplicate match travels down the cells as a ripple chain.
// A held response stalls the execute cycle; the request stays in the capture
// register and o_req_ready stays low until it executes.
// Reset empties the queue and sets arrival order.
`timescale 1ns / 1ps
`default_nettype none
`include "ready_queue_scheduler_core_assert.svh"
module ready_queue_scheduler_core
    import rqs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire t_req              i_req,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output t_rsp                   o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             r_busy;
    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [1:0]       r_policy;
    logic             r_rsp_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    t_entry    w_entry [DEPTH];
    logic      w_ge    [DEPTH];
    logic      w_hit   [DEPTH];
    t_entry    w_new;
    t_cell_ctl w_ctl;
    logic      w_ex;
    logic      w_full;
    logic      w_empty;
    logic      w_found;
    logic      w_ins_ok;
    logic      w_del_ok;
    logic      w_wr;

    assign o_req_ready = !r_busy;
    assign w_ex        = r_busy && (!r_rsp_valid || i_rsp_ready);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_found     = w_hit[DEPTH-1];
    assign w_new       = '{id: r_req.process_id, lifetime: r_req.lifetime,
                           prio: r_req.priority_req};

    assign w_ins_ok  = (r_req.kind == K_ADD) && !w_found && !w_full;
    assign w_del_ok  = ((r_req.kind == K_REMOVE) && w_found) ||
                       ((r_req.kind == K_TAKE) && !w_empty);
    assign w_ctl.ins = w_ex && w_ins_ok;
    assign w_ctl.del = w_ex && w_del_ok;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry w_prev;
            t_entry w_next;
            logic   w_prev_ge;
            logic   w_prev_hit;
            if (g == 0) begin : g_head
                assign w_prev     = w_new;
                assign w_prev_ge  = 1'b0;
                // a take removes the head: start the chain already hit
                assign w_prev_hit = (r_req.kind == K_TAKE);
            end else begin : g_body
                assign w_prev     = w_entry[g-1];
                assign w_prev_ge  = w_ge[g-1];
                assign w_prev_hit = w_hit[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_entry[g+1];
            end
            rqs_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_req      (r_req),
                .i_policy   (r_policy),
                .i_count    (r_count),
                .i_ctl      (w_ctl),
                .i_prev     (w_prev),
                .i_next     (w_next),
                .i_prev_ge  (w_prev_ge),
                .i_prev_hit (w_prev_hit),
                .o_entry    (w_entry[g]),
                .o_ge       (w_ge[g]),
                .o_hit      (w_hit[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_rsp.status  = ST_OK;
        n_rsp.next_id = '0;
        case (r_req.kind)
            K_ADD: begin
                if (w_found) begin
                    n_rsp.status = ST_DUP;
                end else if (w_full) begin
                    n_rsp.status = ST_FULL;
                end
            end
            K_REMOVE: begin
                if (!w_found) begin
                    n_rsp.status = ST_NOTFOUND;
                end
            end
            K_TAKE: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.next_id = w_entry[0].id;
                end
            end
            default: ;
        endcase
        n_rsp.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_req_valid && o_req_ready) begin
                r_busy <= 1'b1;
            end else if (w_ex) begin
                r_busy <= 1'b0;
            end
            if (w_ex) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_req <= i_req;
        end
        if (w_ex) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // register port: policy only changes while the queue is empty
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FCFS;
        end else if (w_wr && (paddr[2] == REG_POLICY) && w_empty) begin
            r_policy <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_POLICY) begin
            prdata = {{(DATA_W-2){1'b0}}, r_policy};
        end
    end

    `RQS_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (!o_rsp_valid && o_req_ready), "not idle after reset")
    `RQS_ASSERT_RUN(a_count_bound, r_count <= CNT_W'(DEPTH), "occupancy above depth")
    `RQS_ASSERT_RUN(a_del_dec, w_ctl.del |=> (r_count + CNT_W'(1)) == $past(r_count), "delete did not shrink queue")
    `RQS_ASSERT_RUN(a_rsp_src, $rose(o_rsp_valid) |-> $past(w_ex), "response without execute")
    `RQS_ASSERT_RUN(a_pol_empty, !$stable(r_policy) |-> ($past(r_count) == '0), "policy changed on busy queue")

endmodule
`default_nettype wire
